// ===== src/trse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// track run sample expander package
// shared types, register map and run flag bit positions
// ----------------------------------------------------------------------------
package trse_pkg;

	// configuration port
	localparam int APB_DW      = 64;
	localparam int APB_AW      = 6;
	localparam int REG_IDX_LSB = 3;

	typedef enum logic [2:0] {
		REG_RUN_FLAGS        = 3'd0,
		REG_BASE_OFFSET      = 3'd1,
		REG_RUN_DATA_OFFSET  = 3'd2,
		REG_FRAG_BOX_OFFSET  = 3'd3,
		REG_DEFAULT_SIZE     = 3'd4,
		REG_DEFAULT_DURATION = 3'd5,
		REG_DEFAULT_FLAGS    = 3'd6,
		REG_FIRST_FLAGS      = 3'd7
	} reg_idx_t;

	// run flag bit positions
	localparam int RF_DATA_OFFSET = 0;
	localparam int RF_FIRST_FLAGS = 2;
	localparam int RF_DURATION    = 8;
	localparam int RF_SIZE        = 9;
	localparam int RF_FLAGS       = 10;
	localparam int RF_CT_OFFSET   = 11;

	// sample flag that marks a non-sync sample
	localparam int NON_SYNC_BIT = 16;

	// queue between front and back, depth a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_ENTRY = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic [11:0]        run_flags;
		logic [63:0]        base_offset;
		logic signed [31:0] run_data_offset;
		logic [63:0]        fragment_box_offset;
		logic [31:0]        default_size;
		logic [31:0]        default_duration;
		logic [31:0]        default_flags;
		logic [31:0]        first_sample_flags;
	} cfg_t;

	// classified item as it travels through the queue
	typedef struct packed {
		item_kind_t  kind;
		logic [63:0] origin_time;
		logic [63:0] position;
		logic [31:0] size;
		logic [31:0] duration;
		logic [31:0] time_offset;
		logic        is_sync;
	} qent_t;

	typedef struct packed {
		logic [63:0] sample_offset;
		logic [31:0] sample_bytes;
		logic [31:0] sample_span;
		logic [63:0] decode_time;
		logic [63:0] present_time;
		logic        is_sync;
		logic [63:0] payload_after;
		logic [63:0] next_time;
	} result_t;

endpackage
`default_nettype wire

// ===== src/trse_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// configuration registers
// apb-style register file holding the run flags, offsets and defaults
// ----------------------------------------------------------------------------
module trse_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [trse_pkg::APB_AW-1:0] paddr,
	input  wire logic [trse_pkg::APB_DW-1:0] pwdata,
	output logic      [trse_pkg::APB_DW-1:0] prdata,
	output logic                             pready,
	output trse_pkg::cfg_t                   cfg
);
	import trse_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:REG_IDX_LSB]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_RUN_FLAGS:        cfg_q.run_flags <= pwdata[11:0];
				REG_BASE_OFFSET:      cfg_q.base_offset <= pwdata;
				REG_RUN_DATA_OFFSET:  cfg_q.run_data_offset <= pwdata[31:0];
				REG_FRAG_BOX_OFFSET:  cfg_q.fragment_box_offset <= pwdata;
				REG_DEFAULT_SIZE:     cfg_q.default_size <= pwdata[31:0];
				REG_DEFAULT_DURATION: cfg_q.default_duration <= pwdata[31:0];
				REG_DEFAULT_FLAGS:    cfg_q.default_flags <= pwdata[31:0];
				REG_FIRST_FLAGS:      cfg_q.first_sample_flags <= pwdata[31:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RUN_FLAGS:        prdata = {52'd0, cfg_q.run_flags};
			REG_BASE_OFFSET:      prdata = cfg_q.base_offset;
			REG_RUN_DATA_OFFSET:  prdata = {32'd0, cfg_q.run_data_offset};
			REG_FRAG_BOX_OFFSET:  prdata = cfg_q.fragment_box_offset;
			REG_DEFAULT_SIZE:     prdata = {32'd0, cfg_q.default_size};
			REG_DEFAULT_DURATION: prdata = {32'd0, cfg_q.default_duration};
			REG_DEFAULT_FLAGS:    prdata = {32'd0, cfg_q.default_flags};
			REG_FIRST_FLAGS:      prdata = {32'd0, cfg_q.first_sample_flags};
		endcase
	end

endmodule
`default_nettype wire

// ===== src/trse_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// front end
// accepts items, resolves run position and per-entry fields from the defaults
// ----------------------------------------------------------------------------
module trse_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire trse_pkg::cfg_t cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           action,
	input  wire logic [63:0]    origin_time,
	input  wire logic [63:0]    payload_position,
	input  wire logic [31:0]    entry_size,
	input  wire logic [31:0]    entry_duration,
	input  wire logic [31:0]    entry_flags,
	input  wire logic [31:0]    entry_time_offset,
	output logic                push_valid,
	input  wire logic           push_ready,
	output trse_pkg::qent_t     push_data
);
	import trse_pkg::*;

	logic        first_pending_q;
	item_kind_t  kind;
	logic [63:0] run_ofs;
	logic [63:0] pos_sum;
	logic [31:0] flags;

	assign kind       = item_kind_t'(action);
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	// run data offset, sign extended when the run carries one
	assign run_ofs = cfg.run_flags[RF_DATA_OFFSET] ?
		{{32{cfg.run_data_offset[31]}}, cfg.run_data_offset} : 64'd0;
	assign pos_sum = cfg.base_offset + run_ofs;

	always_comb begin
		priority if (first_pending_q && cfg.run_flags[RF_FIRST_FLAGS]) begin
			flags = cfg.first_sample_flags;
		end else if (cfg.run_flags[RF_FLAGS]) begin
			flags = entry_flags;
		end else begin
			flags = cfg.default_flags;
		end
	end

	always_comb begin
		push_data.kind        = kind;
		push_data.origin_time = origin_time;
		// player workaround: offset pointing at the fragment box means payload
		push_data.position    = (pos_sum == cfg.fragment_box_offset) ?
			payload_position : pos_sum;
		push_data.size        = cfg.run_flags[RF_SIZE] ? entry_size : cfg.default_size;
		push_data.duration    = cfg.run_flags[RF_DURATION] ?
			entry_duration : cfg.default_duration;
		push_data.time_offset = cfg.run_flags[RF_CT_OFFSET] ? entry_time_offset : 32'd0;
		push_data.is_sync     = !flags[NON_SYNC_BIT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pending_q <= 1'b1;
		end else if (in_valid && push_ready) begin
			first_pending_q <= (kind == KIND_START);
		end
	end

endmodule
`default_nettype wire

// ===== src/trse_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// item queue
// short register queue between the front and back ends
// ----------------------------------------------------------------------------
module trse_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire trse_pkg::qent_t push_data,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output trse_pkg::qent_t      pop_data
);
	import trse_pkg::*;

	qent_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = ent_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_data;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue fill beyond depth");

	a_cnt_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[QPTR_W-1:0] == QPTR_W'(wr_q - rd_q))
		else $error("queue fill disagrees with pointers");

	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue fill missed a push");
`endif

endmodule
`default_nettype wire

// ===== src/trse_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// back end
// applies run starts and emits one sample record per entry
// ----------------------------------------------------------------------------
module trse_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pop_valid,
	output logic                 pop_ready,
	input  wire trse_pkg::qent_t pop_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output trse_pkg::result_t    res
);
	import trse_pkg::*;

	logic [63:0] run_time_q;
	logic [63:0] run_pos_q;
	logic [63:0] total_q;
	logic        out_valid_q;
	result_t     res_q;
	logic        take_start;
	logic        take_entry;
	logic [63:0] pos_next;
	logic [63:0] time_next;

	// a start transfer leaves no record, so it never waits on the output
	assign pop_ready  = (pop_data.kind == KIND_START) || !out_valid_q || out_ready;
	assign take_start = pop_valid && pop_ready && (pop_data.kind == KIND_START);
	assign take_entry = pop_valid && pop_ready && (pop_data.kind == KIND_ENTRY);
	assign pos_next   = run_pos_q + {32'd0, pop_data.size};
	assign time_next  = run_time_q + {32'd0, pop_data.duration};
	assign out_valid  = out_valid_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_time_q  <= '0;
			run_pos_q   <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_start) begin
				run_pos_q  <= pop_data.position;
				run_time_q <= (pop_data.origin_time != 64'd0) ? pop_data.origin_time : total_q;
			end else if (take_entry) begin
				run_pos_q  <= pos_next;
				run_time_q <= time_next;
				total_q    <= total_q + {32'd0, pop_data.duration};
			end
			if (take_entry) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_entry) begin
			res_q.sample_offset <= run_pos_q;
			res_q.sample_bytes  <= pop_data.size;
			res_q.sample_span   <= pop_data.duration;
			res_q.decode_time   <= run_time_q;
			res_q.present_time  <= run_time_q + {32'd0, pop_data.time_offset};
			res_q.is_sync       <= pop_data.is_sync;
			res_q.payload_after <= pos_next;
			res_q.next_time     <= time_next;
		end
	end

endmodule
`default_nettype wire

// ===== src/track_run_sample_expander_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// track run sample expander
// an entry is registered in the queue, then its record in the output register
// throughput: one item per cycle while out_ready takes records; each entry's
// 64-bit offset and time adds close in the back end, which sets the rate
// reset: asynchronous, clears registers, queue and run state; no clearing pass
// ----------------------------------------------------------------------------
module track_run_sample_expander_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [trse_pkg::APB_AW-1:0] paddr,
	input  wire logic [trse_pkg::APB_DW-1:0] pwdata,
	output logic      [trse_pkg::APB_DW-1:0] prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        action,
	input  wire logic [63:0]                 origin_time,
	input  wire logic [63:0]                 payload_position,
	input  wire logic [31:0]                 entry_size,
	input  wire logic [31:0]                 entry_duration,
	input  wire logic [31:0]                 entry_flags,
	input  wire logic [31:0]                 entry_time_offset,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [63:0]                 sample_offset,
	output logic      [31:0]                 sample_bytes,
	output logic      [31:0]                 sample_span,
	output logic      [63:0]                 decode_time,
	output logic      [63:0]                 present_time,
	output logic                             is_sync,
	output logic      [63:0]                 payload_after,
	output logic      [63:0]                 next_time
);
	import trse_pkg::*;

	cfg_t    cfg;
	qent_t   push_data;
	qent_t   pop_data;
	result_t res;
	logic    push_valid;
	logic    push_ready;
	logic    pop_valid;
	logic    pop_ready;

	trse_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	trse_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.action            (action),
		.origin_time       (origin_time),
		.payload_position  (payload_position),
		.entry_size        (entry_size),
		.entry_duration    (entry_duration),
		.entry_flags       (entry_flags),
		.entry_time_offset (entry_time_offset),
		.push_valid        (push_valid),
		.push_ready        (push_ready),
		.push_data         (push_data)
	);

	trse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	trse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign sample_offset = res.sample_offset;
	assign sample_bytes  = res.sample_bytes;
	assign sample_span   = res.sample_span;
	assign decode_time   = res.decode_time;
	assign present_time  = res.present_time;
	assign is_sync       = res.is_sync;
	assign payload_after = res.payload_after;
	assign next_time     = res.next_time;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// track run sample expander testbench
// drives start and entry transfers from a pending queue and configures the
// block over its register port while idle. each accepted entry is expanded
// here into the record it should produce, and every record that leaves the
// block is checked field by field against the oldest one still due
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import trse_pkg::*;

	localparam int     CLK_HALF        = 4;
	localparam int     RESET_CYCLES    = 8;
	localparam int     SETTLE_CYCLES   = 6;
	localparam int     RANDOM_PHASES   = 8;
	localparam int     ITEMS_PER_PHASE = 125;
	localparam longint CYCLE_LIMIT     = 400000;
	localparam int     MAX_PRINTS      = 40;

	typedef struct packed {
		item_kind_t  action;
		logic [63:0] origin_time;
		logic [63:0] payload_position;
		logic [31:0] entry_size;
		logic [31:0] entry_duration;
		logic [31:0] entry_flags;
		logic [31:0] entry_time_offset;
	} run_item_t;

	typedef struct packed {
		logic [63:0] run_time;
		logic [63:0] run_position;
		logic [63:0] payload_offset;
		logic [63:0] total_duration;
		logic        first_pending;
	} run_state_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              action = 1'b0;
	logic [63:0]       origin_time = '0;
	logic [63:0]       payload_position = '0;
	logic [31:0]       entry_size = '0;
	logic [31:0]       entry_duration = '0;
	logic [31:0]       entry_flags = '0;
	logic [31:0]       entry_time_offset = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [63:0]       sample_offset;
	logic [31:0]       sample_bytes;
	logic [31:0]       sample_span;
	logic [63:0]       decode_time;
	logic [63:0]       present_time;
	logic              is_sync;
	logic [63:0]       payload_after;
	logic [63:0]       next_time;

	run_item_t  pending_items[$];
	result_t    records_due[$];
	run_item_t  cur_item;
	cfg_t       cfg_shadow;
	run_state_t run_st;
	logic       no_idle = 1'b1;
	int         send_gap = 0;
	int         hold_gap = 0;
	int         fail_count = 0;
	longint     cycle_count = 0;

	track_run_sample_expander_top i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.action            (action),
		.origin_time       (origin_time),
		.payload_position  (payload_position),
		.entry_size        (entry_size),
		.entry_duration    (entry_duration),
		.entry_flags       (entry_flags),
		.entry_time_offset (entry_time_offset),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.sample_offset     (sample_offset),
		.sample_bytes      (sample_bytes),
		.sample_span       (sample_span),
		.decode_time       (decode_time),
		.present_time      (present_time),
		.is_sync           (is_sync),
		.payload_after     (payload_after),
		.next_time         (next_time)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	function automatic logic [63:0] rand_origin();
		int r;
		r = $urandom_range(0, 19);
		if (r < 5)
			return '0;
		if (r == 5)
			return '1;
		return rand64();
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic run_item_t make_start(input logic [63:0] origin, input logic [63:0] pos);
		run_item_t it;
		it.action            = KIND_START;
		it.origin_time       = origin;
		it.payload_position  = pos;
		it.entry_size        = $urandom;
		it.entry_duration    = $urandom;
		it.entry_flags       = $urandom;
		it.entry_time_offset = $urandom;
		return it;
	endfunction

	function automatic run_item_t make_entry(input logic [31:0] size, input logic [31:0] dur,
			input logic [31:0] flags, input logic [31:0] cto);
		run_item_t it;
		it.action            = KIND_ENTRY;
		it.origin_time       = rand64();
		it.payload_position  = rand64();
		it.entry_size        = size;
		it.entry_duration    = dur;
		it.entry_flags       = flags;
		it.entry_time_offset = cto;
		return it;
	endfunction

	function automatic cfg_t make_cfg(input logic [11:0] flags, input logic [63:0] base,
			input logic [31:0] rdo, input logic [63:0] fbo, input logic [31:0] dsize,
			input logic [31:0] ddur, input logic [31:0] dflags, input logic [31:0] fflags);
		cfg_t c;
		c.run_flags           = flags;
		c.base_offset         = base;
		c.run_data_offset     = rdo;
		c.fragment_box_offset = fbo;
		c.default_size        = dsize;
		c.default_duration    = ddur;
		c.default_flags       = dflags;
		c.first_sample_flags  = fflags;
		return c;
	endfunction

	// run data offset before the fragment box comparison
	function automatic logic [63:0] run_origin(input cfg_t c);
		logic [63:0] pos;
		pos = c.base_offset;
		if (c.run_flags[RF_DATA_OFFSET])
			pos = pos + {{32{c.run_data_offset[31]}}, c.run_data_offset};
		return pos;
	endfunction

	// advance the run state for one accepted transfer, queue the record it yields
	function automatic void expand_item(input run_item_t it);
		logic [63:0] pos;
		logic [31:0] size;
		logic [31:0] dur;
		logic [31:0] flags;
		logic [31:0] cto;
		result_t     rec;
		if (it.action == KIND_START) begin
			pos = run_origin(cfg_shadow);
			// player workaround: offset pointing at the fragment box means payload position
			if (pos == cfg_shadow.fragment_box_offset)
				pos = it.payload_position;
			run_st.run_position   = pos;
			run_st.payload_offset = pos;
			run_st.run_time       = (it.origin_time != '0) ? it.origin_time
			                                               : run_st.total_duration;
			run_st.first_pending  = 1'b1;
		end else begin
			size = cfg_shadow.run_flags[RF_SIZE] ? it.entry_size : cfg_shadow.default_size;
			dur  = cfg_shadow.run_flags[RF_DURATION] ? it.entry_duration
			                                         : cfg_shadow.default_duration;
			if (run_st.first_pending && cfg_shadow.run_flags[RF_FIRST_FLAGS])
				flags = cfg_shadow.first_sample_flags;
			else if (cfg_shadow.run_flags[RF_FLAGS])
				flags = it.entry_flags;
			else
				flags = cfg_shadow.default_flags;
			cto = cfg_shadow.run_flags[RF_CT_OFFSET] ? it.entry_time_offset : '0;

			rec.sample_offset = run_st.run_position;
			rec.sample_bytes  = size;
			rec.sample_span   = dur;
			rec.decode_time   = run_st.run_time;
			rec.present_time  = run_st.run_time + {32'd0, cto};
			rec.is_sync       = ~flags[NON_SYNC_BIT];

			run_st.run_position   = run_st.run_position + {32'd0, size};
			run_st.payload_offset = run_st.payload_offset + {32'd0, size};
			run_st.run_time       = run_st.run_time + {32'd0, dur};
			run_st.total_duration = run_st.total_duration + {32'd0, dur};
			run_st.first_pending  = 1'b0;

			rec.payload_after = run_st.payload_offset;
			rec.next_time     = run_st.run_time;
			records_due.push_back(rec);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(int'(idx) << REG_IDX_LSB);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_config(input cfg_t c);
		write_reg(REG_RUN_FLAGS, {52'd0, c.run_flags});
		write_reg(REG_BASE_OFFSET, c.base_offset);
		write_reg(REG_RUN_DATA_OFFSET, {32'd0, c.run_data_offset});
		write_reg(REG_FRAG_BOX_OFFSET, c.fragment_box_offset);
		write_reg(REG_DEFAULT_SIZE, {32'd0, c.default_size});
		write_reg(REG_DEFAULT_DURATION, {32'd0, c.default_duration});
		write_reg(REG_DEFAULT_FLAGS, {32'd0, c.default_flags});
		write_reg(REG_FIRST_FLAGS, {32'd0, c.first_sample_flags});
		cfg_shadow = c;
	endtask

	// sampled on the falling edge so that every queue and valid has settled
	task automatic wait_idle();
		@(negedge clk);
		while (pending_items.size() != 0 || in_valid || records_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : drive_items
		if (arst_n) begin
			if (in_valid && in_ready)
				expand_item(cur_item);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					action            <= cur_item.action;
					origin_time       <= cur_item.origin_time;
					payload_position  <= cur_item.payload_position;
					entry_size        <= cur_item.entry_size;
					entry_duration    <= cur_item.entry_duration;
					entry_flags       <= cur_item.entry_flags;
					entry_time_offset <= cur_item.entry_time_offset;
					in_valid          <= 1'b1;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_records
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {sample_offset, sample_bytes, sample_span, decode_time, present_time,
			       is_sync, payload_after, next_time};
			if (records_due.size() == 0) begin
				report_mismatch("record with none due", got.sample_offset, '0);
			end else begin
				want = records_due.pop_front();
				if (got.sample_offset !== want.sample_offset)
					report_mismatch("sample_offset", got.sample_offset, want.sample_offset);
				if (got.sample_bytes !== want.sample_bytes)
					report_mismatch("sample_bytes", {32'd0, got.sample_bytes},
						{32'd0, want.sample_bytes});
				if (got.sample_span !== want.sample_span)
					report_mismatch("sample_span", {32'd0, got.sample_span},
						{32'd0, want.sample_span});
				if (got.decode_time !== want.decode_time)
					report_mismatch("decode_time", got.decode_time, want.decode_time);
				if (got.present_time !== want.present_time)
					report_mismatch("present_time", got.present_time, want.present_time);
				if (got.is_sync !== want.is_sync)
					report_mismatch("is_sync", {63'd0, got.is_sync}, {63'd0, want.is_sync});
				if (got.payload_after !== want.payload_after)
					report_mismatch("payload_after", got.payload_after, want.payload_after);
				if (got.next_time !== want.next_time)
					report_mismatch("next_time", got.next_time, want.next_time);
			end
		end
		// receiver stalls
		if (hold_gap > 0) begin
			hold_gap--;
			out_ready <= 1'b0;
		end else begin
			hold_gap = pick_gap();
			out_ready <= (hold_gap == 0);
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin : main
		cfg_t        c;
		logic [63:0] base;
		int          n;
		int          len;
		cfg_shadow = '0;
		run_st = '0;
		run_st.first_pending = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// entries before any start, all registers at reset
		no_idle = 1'b1;
		pending_items.push_back(make_entry(32'h10, 32'h20, 32'h0001_0000, '1));
		pending_items.push_back(make_entry('1, '1, '0, '1));
		wait_idle();

		// every presence bit, negative run offset, first flags override
		write_config(make_cfg(12'hFFF, 64'hFFFF_FFFF_FFFF_FFF0, 32'h8000_0000, '0,
			'1, '1, 32'h0001_0000, 32'h0001_0000));
		pending_items.push_back(make_start('0, rand64()));
		pending_items.push_back(make_entry('1, '1, '0, '1));
		pending_items.push_back(make_entry('0, '0, 32'h0001_0000, '0));
		pending_items.push_back(make_entry('1, '1, '1, '1));
		pending_items.push_back(make_start('1, rand64()));
		pending_items.push_back(make_entry('1, '1, '0, '1));
		pending_items.push_back(make_entry(32'h1234, 32'h5, 32'hFFFE_FFFF, '0));
		wait_idle();

		// only ignored flag bits, offset lands on the fragment box
		write_config(make_cfg(12'h0FA, 64'h1000, 32'h7FFF_FFFF, 64'h1000,
			'1, '0, 32'h0000_FFFF, 32'h0001_0000));
		pending_items.push_back(make_start(64'h5, '1));
		pending_items.push_back(make_entry('1, '1, 32'h0001_0000, '1));
		pending_items.push_back(make_entry('0, '0, '0, '0));
		wait_idle();

		// negative run offset onto the fragment box, composition offset present
		write_config(make_cfg(12'h801, 64'h200, 32'hFFFF_FF00, 64'h100,
			32'h40, 32'h3, 32'h0001_0000, '0));
		pending_items.push_back(make_start('0, 64'hFEDC_BA98_7654_3210));
		pending_items.push_back(make_entry('0, '0, '0, '1));
		pending_items.push_back(make_entry('0, '0, '0, '0));
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == RANDOM_PHASES - 1) begin
				c = make_cfg('1, '1, '1, '1, '1, '1, '1, '1);
			end else begin
				base = ($urandom_range(0, 3) == 0) ? {32'd0, $urandom} : rand64();
				c = make_cfg(12'($urandom_range(0, 4095)), base, rand_word(), '0,
					rand_word(), rand_word(), rand_word(), rand_word());
				c.fragment_box_offset = ($urandom_range(0, 2) == 0) ? run_origin(c) : rand64();
			end
			write_config(c);
			no_idle = (ph % 3 == 0);
			n = 0;
			// mostly whole runs, now and then entries that carry on without a start
			while (n < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 9) != 0) begin
					pending_items.push_back(make_start(rand_origin(), rand64()));
					n++;
				end
				len = $urandom_range(1, 12);
				repeat (len) begin
					pending_items.push_back(make_entry(rand_word(), rand_word(), rand_word(),
						rand_word()));
					n++;
				end
			end
			wait_idle();
		end

		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
